### hw/rtl/fsdc_pkg.sv
// Shared types, tables and small arithmetic helpers for the four-square
// diagonal cipher. No dependencies.
package fsdc_pkg;

  localparam int Side = 5;
  localparam int Cells = 25;
  localparam logic [4:0] CELLS_LIM = 5'd25;
  localparam logic [4:0] FALLBACK_LETTER = 5'd9;

  // Function codes
  localparam logic [1:0] FUNC_ENC = 2'd0;
  localparam logic [1:0] FUNC_DEC = 2'd1;
  localparam logic [1:0] FUNC_LOAD_UPPER = 2'd2;
  localparam logic [1:0] FUNC_LOAD_LOWER = 2'd3;

  // Row and column of a cell index; entries past the square read as zero
  localparam logic [2:0] ROW_OF [32] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };
  localparam logic [2:0] COL_OF [32] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  // Write request into one keyed square
  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [4:0] letter;
  } sq_wr_t;

  // Out-of-range letters fold to the fallback letter
  function automatic logic [4:0] fix_letter(input logic [4:0] v);
    return (v >= CELLS_LIM) ? FALLBACK_LETTER : v;
  endfunction

  // v mod 5 for v in 0..14
  function automatic logic [2:0] mod5(input logic [3:0] v);
    logic [3:0] t;
    if (v >= 4'd10) t = v - 4'd10;
    else if (v >= 4'd5) t = v - 4'd5;
    else t = v;
    return t[2:0];
  endfunction

  // row*5 + col
  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  // Inverse diagonal map on (row, col), giving a cell index
  function automatic logic [4:0] undiag(input logic [2:0] r, input logic [2:0] c);
    logic [2:0] oc;
    logic [2:0] orow;
    oc = mod5({1'b0, c} + 4'd5 - {1'b0, r});
    orow = mod5({1'b0, r} + 4'd5 - {1'b0, oc});
    return cell_of(orow, oc);
  endfunction

endpackage

### hw/rtl/fsdc_square.sv
// One keyed square: letter at each cell and cell of each letter, in flops.
// Depends on fsdc_pkg.
module fsdc_square (
  input  logic               clk,
  input  logic               rst,
  input  fsdc_pkg::sq_wr_t   wr,
  input  logic [4:0]         letter_addr,
  input  logic [4:0]         place_addr,
  output logic [4:0]         letter_rd,
  output logic [4:0]         place_rd
);

  logic [4:0] letters [fsdc_pkg::Cells];
  logic [4:0] places  [fsdc_pkg::Cells];

  // Identity on reset; a load writes the cell and the letter's place
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsdc_pkg::Cells; i++) begin
        letters[i] <= 5'(i);
        places[i]  <= 5'(i);
      end
    end else if (wr.en) begin
      letters[wr.addr]  <= wr.letter;
      places[wr.letter] <= wr.addr;
    end
  end

  // Addresses above the square read as zero
  assign letter_rd = (letter_addr < fsdc_pkg::CELLS_LIM) ? letters[letter_addr] : 5'd0;
  assign place_rd  = (place_addr < fsdc_pkg::CELLS_LIM) ? places[place_addr] : 5'd0;

endmodule

### hw/rtl/fsdc_pair.sv
// Pair datapath: diagonal map, square addressing and inverse map.
// Depends on fsdc_pkg; reads are served by two fsdc_square instances.
module fsdc_pair (
  input  logic [4:0] a,
  input  logic [4:0] b,
  input  logic       decrypt,
  output logic [4:0] upper_cell,
  output logic [4:0] lower_cell,
  input  logic [4:0] upper_letter,
  input  logic [4:0] lower_letter,
  input  logic [4:0] upper_place,
  input  logic [4:0] lower_place,
  output logic [4:0] res_first,
  output logic [4:0] res_second
);

  logic [2:0] ar, ac, br, bc;
  logic [2:0] r1, c1, r2, c2;
  logic [2:0] pr1, pc1, pr2, pc2;

  // Diagonal map of both input letters
  always_comb begin
    ar = fsdc_pkg::ROW_OF[a];
    ac = fsdc_pkg::COL_OF[a];
    br = fsdc_pkg::ROW_OF[b];
    bc = fsdc_pkg::COL_OF[b];
    r1 = fsdc_pkg::mod5({1'b0, ar} + {1'b0, ac});
    c1 = fsdc_pkg::mod5({1'b0, ar} + {ac, 1'b0});
    r2 = fsdc_pkg::mod5({1'b0, br} + {1'b0, bc});
    c2 = fsdc_pkg::mod5({1'b0, br} + {bc, 1'b0});
  end

  assign upper_cell = fsdc_pkg::cell_of(r1, c2);
  assign lower_cell = fsdc_pkg::cell_of(r2, c1);

  // Decrypt: places back through the inverse map; encrypt: letters from the squares
  always_comb begin
    pr1 = fsdc_pkg::ROW_OF[upper_place];
    pc1 = fsdc_pkg::COL_OF[upper_place];
    pr2 = fsdc_pkg::ROW_OF[lower_place];
    pc2 = fsdc_pkg::COL_OF[lower_place];
    if (decrypt) begin
      res_first  = fsdc_pkg::undiag(pr1, pc2);
      res_second = fsdc_pkg::undiag(pr2, pc1);
    end else begin
      res_first  = upper_letter;
      res_second = lower_letter;
    end
  end

endmodule

### hw/rtl/four_square_diagonal_cipher.sv
// Top level of the four-square diagonal cipher: input register, two keyed
// squares, pair datapath and result register. Depends on fsdc_pkg,
// fsdc_square and fsdc_pair.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+------------------------------------------
//   item    | item_valid   | item_ready   | func, first_letter, second_letter, cell_req
//   result  | result_valid | result_ready | out_first, out_second
//
// One item per cycle sustained while results are taken; a pair's result passes
// the input register, then the result register. Loads give no result and
// update the squares as they leave the input register, so a following pair
// sees them. Reset sets both squares to identity and empties both registers.
// A stalled result holds the input register for pairs only; loads pass on.
module four_square_diagonal_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] func,
  input  logic [4:0] first_letter,
  input  logic [4:0] second_letter,
  input  logic [4:0] cell_req,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [4:0] out_first,
  output logic [4:0] out_second
);

  logic       s1_valid;
  logic [1:0] s1_func;
  logic [4:0] s1_a;
  logic [4:0] s1_b;
  logic [4:0] s1_cell;
  logic       s1_load;
  logic       s1_go;

  fsdc_pkg::sq_wr_t upper_wr, lower_wr;
  logic [4:0] upper_cell, lower_cell;
  logic [4:0] upper_letter, lower_letter, upper_place, lower_place;
  logic [4:0] res_first, res_second;

  // Stage advance: loads always move, pairs need room in the result register
  assign s1_load    = (s1_func == fsdc_pkg::FUNC_LOAD_UPPER)
                   || (s1_func == fsdc_pkg::FUNC_LOAD_LOWER);
  assign s1_go      = s1_valid && (s1_load || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_func <= func;
      s1_a    <= fsdc_pkg::fix_letter(first_letter);
      s1_b    <= fsdc_pkg::fix_letter(second_letter);
      s1_cell <= cell_req;
    end
  end

  // Square writes; cells past the square are dropped
  always_comb begin
    upper_wr.en     = s1_go && (s1_func == fsdc_pkg::FUNC_LOAD_UPPER)
                   && (s1_cell < fsdc_pkg::CELLS_LIM);
    upper_wr.addr   = s1_cell;
    upper_wr.letter = s1_a;
    lower_wr.en     = s1_go && (s1_func == fsdc_pkg::FUNC_LOAD_LOWER)
                   && (s1_cell < fsdc_pkg::CELLS_LIM);
    lower_wr.addr   = s1_cell;
    lower_wr.letter = s1_a;
  end

  fsdc_square u_upper (
    .clk         (clk),
    .rst         (rst),
    .wr          (upper_wr),
    .letter_addr (upper_cell),
    .place_addr  (s1_a),
    .letter_rd   (upper_letter),
    .place_rd    (upper_place)
  );

  fsdc_square u_lower (
    .clk         (clk),
    .rst         (rst),
    .wr          (lower_wr),
    .letter_addr (lower_cell),
    .place_addr  (s1_b),
    .letter_rd   (lower_letter),
    .place_rd    (lower_place)
  );

  fsdc_pair u_pair (
    .a            (s1_a),
    .b            (s1_b),
    .decrypt      (s1_func == fsdc_pkg::FUNC_DEC),
    .upper_cell   (upper_cell),
    .lower_cell   (lower_cell),
    .upper_letter (upper_letter),
    .lower_letter (lower_letter),
    .upper_place  (upper_place),
    .lower_place  (lower_place),
    .res_first    (res_first),
    .res_second   (res_second)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && !s1_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_load) begin
      out_first  <= res_first;
      out_second <= res_second;
    end
  end

  // A pair leaving the input register always lands in the result register
  a_pair_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_load) |=> result_valid)
    else $error("pair lost between stages");

  // An empty input register always takes a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> item_ready)
    else $error("input register empty but not ready");

  // A held pair keeps its operands
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_a) && $stable(s1_b)))
    else $error("held pair changed");

  // Results are always letters of the square
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (out_first < 5'd25 && out_second < 5'd25))
    else $error("result letter out of range");

endmodule
